FILE: rtl/core/sem_pkg.sv
// Shared types and constants for the RGB Sobel edge magnitude block.
// Used by sem_front, sem_queue, sem_back and sobel_edge_magnitude_rgb.
package sem_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	localparam int COL_W     = ADDR_W + 1;
	localparam int ROW_W     = 16;
	localparam int CFG_WID_W = 12;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 16;
	localparam int PIX_W     = 8;
	localparam int RGB_W     = 3 * PIX_W;
	localparam int GRAD_W    = 12;
	localparam int SUM_W     = 22;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

	typedef logic [RGB_W-1:0] rgb_t;

	// one column of the 3x3 window, top row first
	typedef struct packed {
		rgb_t top;
		rgb_t mid;
		rgb_t bot;
	} vec_t;

	typedef struct packed {
		logic last;
		vec_t left;
		vec_t center;
		vec_t right;
	} nbhd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic {
		F_TAKE,
		F_EXEC
	} front_st_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_GRAD,
		B_SQR,
		B_ROOT,
		B_OUT
	} back_st_t;

endpackage

FILE: rtl/core/sem_front.sv
// Front end: accepts pixels and drain beats, keeps the two-row line store and
// the 3x3 window, and queues masked neighborhoods. Depends on sem_pkg.
module sem_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    abort,
	input  logic [sem_pkg::COL_W-1:0] width,
	input  logic [sem_pkg::ROW_W-1:0] height,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [23:0]             s_tdata,  // pixel_red, pixel_green, pixel_blue
	input  logic                    s_tuser,  // action
	output logic                    push,
	output sem_pkg::nbhd_t          push_data,
	input  sem_pkg::q_stat_t        q_stat
);
	import sem_pkg::*;

	front_st_t state_q, state_n;

	logic [2*RGB_W-1:0] mem [MAX_WIDTH];
	logic [2*RGB_W-1:0] rd_q;
	rgb_t               pix_q;
	logic               drain_q;
	vec_t               win_q [3];

	logic [COL_W-1:0]   in_col_q;
	logic [ROW_W-1:0]   in_row_q;
	logic [ADDR_W-1:0]  out_col_q;
	logic [ROW_W-1:0]   out_row_q;

	logic complete, store, emit, proceed, last;
	logic m_left, m_right, m_top, m_bot;
	vec_t new_vec;
	vec_t sh [3];

	always_comb begin
		complete = (in_row_q == height);
		store    = !drain_q && !complete;
		if (drain_q) begin
			emit = complete;
		end else begin
			emit = !complete && ((in_row_q >= ROW_W'(2)) ||
				((in_row_q == ROW_W'(1)) && (in_col_q != '0)));
		end
		proceed = (state_q == F_EXEC) && (!emit || !q_stat.full);

		m_left  = (out_col_q == '0);
		m_right = ({1'b0, out_col_q} == width - COL_W'(1));
		m_top   = (out_row_q == '0);
		m_bot   = (out_row_q == height - ROW_W'(1));
		last    = m_right && m_bot;

		// older row sits in the low half of a line store entry
		new_vec.top = rd_q[RGB_W-1:0];
		new_vec.mid = rd_q[2*RGB_W-1:RGB_W];
		new_vec.bot = drain_q ? '0 : pix_q;
		sh[0] = win_q[1];
		sh[1] = win_q[2];
		sh[2] = new_vec;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vec_t v;
			v = sh[i];
			if (m_top) v.top = '0;
			if (m_bot) v.bot = '0;
			if ((i == 0 && m_left) || (i == 2 && m_right)) v = '0;
			if (i == 0) push_data.left = v;
			else if (i == 1) push_data.center = v;
			else push_data.right = v;
		end
		push_data.last = last;
	end

	assign push = proceed && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_TAKE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			F_TAKE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_n = F_EXEC;
			end
			F_EXEC: begin
				if (proceed) state_n = F_TAKE;
			end
			default: state_n = F_TAKE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			rd_q    <= mem[in_col_q[ADDR_W-1:0]];
			pix_q   <= s_tdata;
			drain_q <= s_tuser;
		end
		if (proceed && store) begin
			mem[in_col_q[ADDR_W-1:0]] <= {pix_q, rd_q[2*RGB_W-1:RGB_W]};
		end
		if (proceed && (store || emit)) begin
			for (int i = 0; i < 3; i++) win_q[i] <= sh[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (abort || (push && last)) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (proceed) begin
			if (store) begin
				if (in_col_q + COL_W'(1) == width) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + ROW_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
			end else if (drain_q && complete) begin
				in_col_q <= in_col_q + COL_W'(1);
			end
			if (emit) begin
				if (m_right) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + ROW_W'(1);
				end else begin
					out_col_q <= out_col_q + ADDR_W'(1);
				end
			end
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full) else $error("push into full queue");
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_row_q <= height) else $error("input row past frame");
	a_out_behind: assert property (@(posedge clk) disable iff (!arst_n)
		out_row_q <= in_row_q) else $error("result position ahead of input");
	a_out_col: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, out_col_q} < width) else $error("result column past width");

endmodule

FILE: rtl/core/sem_queue.sv
// Two-entry queue of neighborhoods between front and back end.
// Depends on sem_pkg.
module sem_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sem_pkg::nbhd_t   push_data,
	input  logic             pop,
	output sem_pkg::nbhd_t   pop_data,
	output sem_pkg::q_stat_t q_stat
);
	import sem_pkg::*;

	nbhd_t      ent_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign pop_data     = ent_q[rd_q];
	assign q_stat.full  = (cnt_q == 2'd2);
	assign q_stat.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

FILE: rtl/core/sem_back.sv
// Back end: Sobel gradients, squared sum and an iterative rounded square
// root per channel, with a registered output. Depends on sem_pkg.
module sem_back (
	input  logic             clk,
	input  logic             arst_n,
	output logic             pop,
	input  sem_pkg::nbhd_t   pop_data,
	input  sem_pkg::q_stat_t q_stat,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,  // edge_red, edge_green, edge_blue
	output logic             m_tlast   // last_of_frame
);
	import sem_pkg::*;

	back_st_t state_q, state_n;

	nbhd_t                     ent_q;
	logic signed [GRAD_W-1:0]  gx_q [3];
	logic signed [GRAD_W-1:0]  gy_q [3];
	logic [SUM_W-1:0]          rem_q [3];
	logic [SUM_W-1:0]          root_q [3];
	logic [SUM_W-1:0]          bit_q;
	logic [SUM_W-1:0]          rem_n [3];
	logic [SUM_W-1:0]          root_n [3];
	logic [PIX_W-1:0]          mag [3];
	logic                      m_tvalid_q, m_tlast_q;
	logic [RGB_W-1:0]          m_tdata_q;
	logic                      load_out;

	function automatic logic signed [GRAD_W-1:0] px(input rgb_t p, input int ch);
		return $signed(GRAD_W'(p[ch*PIX_W +: PIX_W]));
	endfunction

	assign pop      = (state_q == B_IDLE) && !q_stat.empty;
	assign load_out = (state_q == B_OUT) && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			logic [SUM_W-1:0] t;
			logic [SUM_W-1:0] r;
			t = root_q[ch] + bit_q;
			if (rem_q[ch] >= t) begin
				rem_n[ch]  = rem_q[ch] - t;
				root_n[ch] = (root_q[ch] >> 1) + bit_q;
			end else begin
				rem_n[ch]  = rem_q[ch];
				root_n[ch] = root_q[ch] >> 1;
			end
			// round to nearest: remainder above root means above root + 1/2
			r = root_q[ch] + SUM_W'(rem_q[ch] > root_q[ch]);
			mag[ch] = (r > SUM_W'(255)) ? 8'hFF : r[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			B_IDLE: if (!q_stat.empty) state_n = B_GRAD;
			B_GRAD: state_n = B_SQR;
			B_SQR:  state_n = B_ROOT;
			B_ROOT: if (bit_q == SUM_W'(1)) state_n = B_OUT;
			B_OUT:  if (load_out) state_n = B_IDLE;
			default: state_n = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) ent_q <= pop_data;
		unique case (state_q)
			B_GRAD: begin
				for (int ch = 0; ch < 3; ch++) begin
					gx_q[ch] <= GRAD_W'((px(ent_q.right.top, ch)
						+ 2 * px(ent_q.right.mid, ch)
						+ px(ent_q.right.bot, ch)) - (px(ent_q.left.top, ch)
						+ 2 * px(ent_q.left.mid, ch) + px(ent_q.left.bot, ch)));
					gy_q[ch] <= GRAD_W'((px(ent_q.left.bot, ch)
						+ 2 * px(ent_q.center.bot, ch)
						+ px(ent_q.right.bot, ch)) - (px(ent_q.left.top, ch)
						+ 2 * px(ent_q.center.top, ch) + px(ent_q.right.top, ch)));
				end
			end
			B_SQR: begin
				for (int ch = 0; ch < 3; ch++) begin
					rem_q[ch]  <= SUM_W'(unsigned'(SUM_W'(gx_q[ch]) * SUM_W'(gx_q[ch])))
						+ SUM_W'(unsigned'(SUM_W'(gy_q[ch]) * SUM_W'(gy_q[ch])));
					root_q[ch] <= '0;
				end
				bit_q <= SUM_W'(1) << (SUM_W - 2);
			end
			B_ROOT: begin
				for (int ch = 0; ch < 3; ch++) begin
					rem_q[ch]  <= rem_n[ch];
					root_q[ch] <= root_n[ch];
				end
				bit_q <= bit_q >> 2;
			end
			default: ;
		endcase
		if (load_out) begin
			m_tdata_q <= {mag[2], mag[1], mag[0]};
			m_tlast_q <= ent_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	a_root_bit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_ROOT |-> $onehot(bit_q)) else $error("root step bit lost");
	a_sqr_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_SQR |=> state_q == B_ROOT) else $error("square not followed by root");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == B_GRAD) else $error("pop without gradient step");

endmodule

FILE: rtl/core/sobel_edge_magnitude_rgb.sv
// Sobel 3x3 gradient magnitude on RGB raster frames; top level.
// Flow: the front end takes an item, then holds s_tready low for the
// registered line store read then write, waiting for queue room; the back
// end pops a new item only after its 11-step root and output are done.
// Reset: position counters clear, frame size 640 x 480; line store is not
// cleared, as only rows of the current frame are read.
module sobel_edge_magnitude_rgb (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // pixel_red, pixel_green, pixel_blue
	input  logic        s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // edge_red, edge_green, edge_blue
	output logic        m_tlast,   // last_of_frame
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sem_pkg::CFG_DAT_W-1:0] cfg_data
);
	import sem_pkg::*;

	logic [CFG_WID_W-1:0] width_raw_q;
	logic [ROW_W-1:0]     height_raw_q;
	logic [COL_W-1:0]     width;
	logic [ROW_W-1:0]     height;
	logic                 abort, push, pop;
	nbhd_t                push_data, pop_data;
	q_stat_t              q_stat;

	assign cfg_ready = 1'b1;
	assign abort = cfg_valid && ((cfg_index == REG_FRAME_WIDTH) ||
		(cfg_index == REG_FRAME_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_raw_q  <= CFG_WID_W'(640);
			height_raw_q <= ROW_W'(480);
		end else if (cfg_valid) begin
			if (cfg_index == REG_FRAME_WIDTH) width_raw_q <= cfg_data[CFG_WID_W-1:0];
			if (cfg_index == REG_FRAME_HEIGHT) height_raw_q <= cfg_data;
		end
	end

	// clamp into the supported range
	always_comb begin
		if (width_raw_q < CFG_WID_W'(2)) width = COL_W'(2);
		else if (32'(width_raw_q) > MAX_WIDTH) width = COL_W'(MAX_WIDTH);
		else width = COL_W'(width_raw_q);
		height = (height_raw_q < ROW_W'(2)) ? ROW_W'(2) : height_raw_q;
	end

	sem_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.abort     (abort),
		.width     (width),
		.height    (height),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push      (push),
		.push_data (push_data),
		.q_stat    (q_stat)
	);

	sem_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	sem_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop      (pop),
		.pop_data (pop_data),
		.q_stat   (q_stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
